@@ design/vui_hrd_syntax_parser_defines.svh @@
// Assertion helpers shared by the parser modules.
`ifndef VUI_HRD_SYNTAX_PARSER_DEFINES_SVH
`define VUI_HRD_SYNTAX_PARSER_DEFINES_SVH

// cond must never hold at a clock edge outside reset
`define VHP_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("check failed: never");

// a at an edge implies b at the same edge
`define VHP_ASSERT_IMP(lbl, clk_s, rst_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (b)) \
    else $error("check failed: implication");

// a at an edge implies b at the next edge
`define VHP_ASSERT_NEXT(lbl, clk_s, rst_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (b)) \
    else $error("check failed: next");

`endif

@@ design/vhp_pkg.sv @@
package vhp_pkg;

  localparam logic [5:0] PHASE_IDLE   = 6'd63;
  localparam logic [5:0] LAST_ELEMENT = 6'd41;

  localparam logic [5:0] E_AR_FLAG   = 6'd0;
  localparam logic [5:0] E_AR_IDC    = 6'd1;
  localparam logic [5:0] E_SAR_W     = 6'd2;
  localparam logic [5:0] E_OVS_FLAG  = 6'd4;
  localparam logic [5:0] E_OVS_APP   = 6'd5;
  localparam logic [5:0] E_VS_FLAG   = 6'd6;
  localparam logic [5:0] E_VFORMAT   = 6'd7;
  localparam logic [5:0] E_FULLRANGE = 6'd8;
  localparam logic [5:0] E_COL_FLAG  = 6'd9;
  localparam logic [5:0] E_COL_PRIM  = 6'd10;
  localparam logic [5:0] E_COL_TRC   = 6'd11;
  localparam logic [5:0] E_COL_MAT   = 6'd12;
  localparam logic [5:0] E_CHR_FLAG  = 6'd13;
  localparam logic [5:0] E_CHR_TOP   = 6'd14;
  localparam logic [5:0] E_CHR_BOT   = 6'd15;
  localparam logic [5:0] E_TIM_FLAG  = 6'd16;
  localparam logic [5:0] E_FIXED     = 6'd19;
  localparam logic [5:0] E_NAL_FLAG  = 6'd20;
  localparam logic [5:0] E_CPB_CNT   = 6'd21;
  localparam logic [5:0] E_BR_VAL    = 6'd24;
  localparam logic [5:0] E_CBR       = 6'd26;
  localparam logic [5:0] E_INIT_LEN  = 6'd27;
  localparam logic [5:0] E_RMV_LEN   = 6'd28;
  localparam logic [5:0] E_DPB_LEN   = 6'd29;
  localparam logic [5:0] E_TOFF_LEN  = 6'd30;
  localparam logic [5:0] E_VCL_FLAG  = 6'd31;
  localparam logic [5:0] E_LOW_DELAY = 6'd32;
  localparam logic [5:0] E_PIC_STRUCT = 6'd33;
  localparam logic [5:0] E_BSR_FLAG  = 6'd34;
  localparam logic [5:0] E_MV_OVER   = 6'd35;
  localparam logic [5:0] E_BYTES_DEN = 6'd36;
  localparam logic [5:0] E_BITS_DEN  = 6'd37;
  localparam logic [5:0] E_MV_H      = 6'd38;
  localparam logic [5:0] E_MV_V      = 6'd39;
  localparam logic [5:0] E_REORDER   = 6'd40;
  localparam logic [5:0] E_DECBUF    = 6'd41;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_VUI = 2'd1;
  localparam logic [1:0] ST_HRD = 2'd2;

  localparam logic [1:0] CFG_PROFILE    = 2'd0;
  localparam logic [1:0] CFG_CONSTRAINT = 2'd1;
  localparam logic [1:0] CFG_MAX_DPB    = 2'd2;

  localparam logic [3:0] B_NONE      = 4'd0;
  localparam logic [3:0] B_ASPECT    = 4'd1;
  localparam logic [3:0] B_VSIGNAL   = 4'd2;
  localparam logic [3:0] B_COLOUR    = 4'd3;
  localparam logic [3:0] B_CHROMA    = 4'd4;
  localparam logic [3:0] B_TIMING    = 4'd5;
  localparam logic [3:0] B_HRD_NAL   = 4'd6;
  localparam logic [3:0] B_HRD_VCL   = 4'd7;
  localparam logic [3:0] B_HRD_VCLLD = 4'd8;
  localparam logic [3:0] B_RESTRICT  = 4'd9;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [5:0]  elem;
    logic [4:0]  idx;
    logic [31:0] value;
    logic        sel;
    logic [3:0]  burst;
    logic [4:0]  aux;
    logic [1:0]  status;
    logic        done;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  elem;
    logic [31:0] value;
    logic        sel;
  } item_t;

  function automatic logic [5:0] elem_width(input logic [5:0] e);
    logic [5:0] w;
    w = 6'd0;
    case (e) inside
      6'd0, 6'd4, 6'd5, 6'd6, 6'd8, 6'd9, 6'd13, 6'd16, 6'd19, 6'd20,
      6'd26, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35: w = 6'd1;
      6'd1, 6'd10, 6'd11, 6'd12: w = 6'd8;
      6'd2, 6'd3: w = 6'd16;
      6'd7: w = 6'd3;
      6'd17, 6'd18: w = 6'd32;
      6'd22, 6'd23: w = 6'd4;
      6'd27, 6'd28, 6'd29, 6'd30: w = 6'd5;
      default: w = 6'd0;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] burst_len(input logic [3:0] b);
    logic [2:0] n;
    n = 3'd0;
    case (b) inside
      B_ASPECT, B_TIMING: n = 3'd1;
      B_CHROMA: n = 3'd2;
      B_COLOUR: n = 3'd3;
      B_VSIGNAL, B_HRD_NAL, B_HRD_VCL: n = 3'd5;
      B_HRD_VCLLD: n = 3'd6;
      B_RESTRICT: n = 3'd7;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic item_t hrd_item(input logic [2:0] k, input logic sel);
    item_t it;
    it.sel = sel;
    it.value = 32'd23;
    case (k)
      3'd1: begin it.elem = E_CPB_CNT; it.value = 32'd0; end
      3'd2: it.elem = E_INIT_LEN;
      3'd3: it.elem = E_RMV_LEN;
      3'd4: it.elem = E_DPB_LEN;
      default: begin it.elem = E_TOFF_LEN; it.value = 32'd24; end
    endcase
    return it;
  endfunction

  function automatic item_t burst_item(input logic [3:0] b, input logic [2:0] k,
                                       input logic [4:0] aux);
    item_t it;
    it = '0;
    case (b)
      B_ASPECT: it.elem = E_AR_IDC;
      B_VSIGNAL: begin
        case (k)
          3'd1: begin it.elem = E_VFORMAT; it.value = 32'd5; end
          3'd2: it.elem = E_FULLRANGE;
          3'd3: begin it.elem = E_COL_PRIM; it.value = 32'd2; end
          3'd4: begin it.elem = E_COL_TRC; it.value = 32'd2; end
          default: begin it.elem = E_COL_MAT; it.value = 32'd2; end
        endcase
      end
      B_COLOUR: begin
        it.value = 32'd2;
        case (k)
          3'd1: it.elem = E_COL_PRIM;
          3'd2: it.elem = E_COL_TRC;
          default: it.elem = E_COL_MAT;
        endcase
      end
      B_CHROMA: it.elem = (k == 3'd1) ? E_CHR_TOP : E_CHR_BOT;
      B_TIMING: it.elem = E_FIXED;
      B_HRD_NAL: it = hrd_item(k, 1'b0);
      B_HRD_VCL: it = hrd_item(k, 1'b1);
      B_HRD_VCLLD: begin
        if (k == 3'd6) begin
          it.elem = E_LOW_DELAY;
          it.value = {31'd0, aux[0]};
        end else begin
          it = hrd_item(k, 1'b1);
        end
      end
      B_RESTRICT: begin
        case (k)
          3'd1: begin it.elem = E_MV_OVER; it.value = 32'd1; end
          3'd2: begin it.elem = E_BYTES_DEN; it.value = 32'd2; end
          3'd3: begin it.elem = E_BITS_DEN; it.value = 32'd1; end
          3'd4: begin it.elem = E_MV_H; it.value = 32'd15; end
          3'd5: begin it.elem = E_MV_V; it.value = 32'd15; end
          3'd6: begin it.elem = E_REORDER; it.value = {27'd0, aux}; end
          default: begin it.elem = E_DECBUF; it.value = {27'd0, aux}; end
        endcase
      end
      default: it = '0;
    endcase
    return it;
  endfunction

endpackage

@@ design/vui_hrd_syntax_parser.sv @@
// H.264 VUI / HRD syntax parser. Takes one payload bit per cycle and emits one
// result word per completed syntax element, plus default words for absent
// branches. A bit is accepted every cycle while the four-entry command queue
// has room; the output side drains one result word per cycle unless out_stall
// holds it, so a bit that completes an element with a default burst (up to
// eight words) holds the output while later bits keep filling the queue.
module vui_hrd_syntax_parser #(
  parameter int MAX_CPB_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        bit_req,
  input  logic        begin_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  element,
  output logic [4:0]  entry_index,
  output logic [31:0] value,
  output logic        hrd_select,
  output logic [1:0]  status,
  output logic        done_res,
  output logic        last
);

  vhp_pkg::cmd_t cmd, head;
  logic push, pop, head_valid, full, accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  vhp_front #(.MAX_CPB_ENTRIES(MAX_CPB_ENTRIES)) u_front (
    .clk, .rst, .cfg_en, .cfg_index, .cfg_data,
    .accept, .bit_req, .begin_req, .push, .cmd
  );

  vhp_queue u_queue (
    .clk, .rst, .push, .push_data(cmd), .pop, .head, .head_valid, .full
  );

  vhp_back u_back (
    .clk, .rst, .head, .head_valid, .pop, .out_valid, .out_stall,
    .element, .entry_index, .value, .hrd_select, .status, .done_res, .last
  );

endmodule

@@ design/vhp_front.sv @@
module vhp_front #(
  parameter int MAX_CPB_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_en,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              accept,
  input  logic              bit_req,
  input  logic              begin_req,
  output logic              push,
  output vhp_pkg::cmd_t     cmd
);

  logic [7:0]  profile;
  logic        constraint_three;
  logic [4:0]  max_dpb;

  logic [5:0]  phase, phase_next;
  logic [5:0]  zero_count, zero_count_next;
  logic [31:0] acc, acc_next;
  logic [5:0]  bits_left, bits_left_next;
  logic        in_suffix, in_suffix_next;
  logic        hrd_which, hrd_which_next;
  logic [4:0]  cpb_last, cpb_last_next;
  logic [4:0]  cpb_pos, cpb_pos_next;
  logic        nal_present, nal_present_next;
  logic        fixed_rate, fixed_rate_next;

  logic [5:0]  c_phase, c_zc, c_bl, w, zc1;
  logic [31:0] c_acc, acc_sh, v;
  logic        c_insuf, fire, do_enter, stop, in_hrd, per_entry, intra;

  always_comb begin
    c_phase = begin_req ? vhp_pkg::E_AR_FLAG : phase;
    c_acc   = begin_req ? 32'd0 : acc;
    c_zc    = begin_req ? 6'd0 : zero_count;
    c_insuf = begin_req ? 1'b0 : in_suffix;
    c_bl    = begin_req ? vhp_pkg::elem_width(vhp_pkg::E_AR_FLAG) : bits_left;
    phase_next       = c_phase;
    acc_next         = c_acc;
    zero_count_next  = c_zc;
    in_suffix_next   = c_insuf;
    bits_left_next   = c_bl;
    hrd_which_next   = begin_req ? 1'b0 : hrd_which;
    cpb_last_next    = begin_req ? 5'd0 : cpb_last;
    cpb_pos_next     = begin_req ? 5'd0 : cpb_pos;
    nal_present_next = begin_req ? 1'b0 : nal_present;
    fixed_rate_next  = begin_req ? 1'b0 : fixed_rate;
    w = vhp_pkg::elem_width(c_phase);
    acc_sh = {c_acc[30:0], bit_req};
    zc1 = c_zc + 6'd1;
    fire = 1'b0;
    v = 32'd0;
    do_enter = 1'b0;
    stop = 1'b0;
    intra = 1'b0;
    in_hrd = (c_phase >= vhp_pkg::E_CPB_CNT) && (c_phase <= vhp_pkg::E_TOFF_LEN);
    per_entry = (c_phase >= vhp_pkg::E_BR_VAL) && (c_phase <= vhp_pkg::E_CBR);
    cmd = '0;
    cmd.elem  = c_phase;
    cmd.idx   = per_entry ? cpb_pos_next : 5'd0;
    cmd.sel   = in_hrd ? hrd_which_next : 1'b0;
    cmd.burst = vhp_pkg::B_NONE;
    push = 1'b0;

    if (c_phase <= vhp_pkg::LAST_ELEMENT) begin
      if (w != 6'd0) begin
        acc_next = acc_sh;
        bits_left_next = c_bl - 6'd1;
        if (c_bl == 6'd1) begin
          fire = 1'b1;
          v = acc_sh;
        end
      end else if (!c_insuf) begin
        if (!bit_req) begin
          zero_count_next = zc1;
          if (zc1 > 6'd31) begin
            push = 1'b1;
            cmd.status = in_hrd ? vhp_pkg::ST_HRD : vhp_pkg::ST_VUI;
            cmd.done = 1'b1;
            phase_next = vhp_pkg::PHASE_IDLE;
          end
        end else if (c_zc == 6'd0) begin
          fire = 1'b1;
        end else begin
          in_suffix_next = 1'b1;
          bits_left_next = c_zc;
          acc_next = 32'd0;
        end
      end else begin
        acc_next = acc_sh;
        bits_left_next = c_bl - 6'd1;
        if (c_bl == 6'd1) begin
          fire = 1'b1;
          v = ((32'd1 << c_zc[4:0]) - 32'd1) + acc_sh;
        end
      end
    end

    if (fire) begin
      push = 1'b1;
      cmd.value = v;
      do_enter = 1'b1;
      phase_next = c_phase + 6'd1;
      unique case (c_phase) inside
        vhp_pkg::E_AR_FLAG: begin
          if (v[0]) phase_next = vhp_pkg::E_AR_IDC;
          else begin
            cmd.burst = vhp_pkg::B_ASPECT;
            phase_next = vhp_pkg::E_OVS_FLAG;
          end
        end
        vhp_pkg::E_AR_IDC:
          phase_next = (v == 32'd255) ? vhp_pkg::E_SAR_W : vhp_pkg::E_OVS_FLAG;
        vhp_pkg::E_OVS_FLAG:
          phase_next = v[0] ? vhp_pkg::E_OVS_APP : vhp_pkg::E_VS_FLAG;
        vhp_pkg::E_VS_FLAG: begin
          if (!v[0]) begin
            cmd.burst = vhp_pkg::B_VSIGNAL;
            phase_next = vhp_pkg::E_CHR_FLAG;
          end
        end
        vhp_pkg::E_COL_FLAG: begin
          if (!v[0]) begin
            cmd.burst = vhp_pkg::B_COLOUR;
            phase_next = vhp_pkg::E_CHR_FLAG;
          end
        end
        vhp_pkg::E_CHR_FLAG: begin
          if (!v[0]) begin
            cmd.burst = vhp_pkg::B_CHROMA;
            phase_next = vhp_pkg::E_TIM_FLAG;
          end
        end
        vhp_pkg::E_CHR_TOP, vhp_pkg::E_CHR_BOT: begin
          if (v > 32'd5) begin
            stop = 1'b1;
            cmd.status = vhp_pkg::ST_VUI;
          end
        end
        vhp_pkg::E_TIM_FLAG: begin
          if (!v[0]) begin
            fixed_rate_next = 1'b0;
            cmd.burst = vhp_pkg::B_TIMING;
            phase_next = vhp_pkg::E_NAL_FLAG;
          end
        end
        vhp_pkg::E_FIXED: fixed_rate_next = v[0];
        vhp_pkg::E_NAL_FLAG: begin
          nal_present_next = v[0];
          if (v[0]) begin
            hrd_which_next = 1'b0;
          end else begin
            cmd.burst = vhp_pkg::B_HRD_NAL;
            phase_next = vhp_pkg::E_VCL_FLAG;
          end
        end
        vhp_pkg::E_CPB_CNT: begin
          if (v > 32'(MAX_CPB_ENTRIES - 1)) begin
            stop = 1'b1;
            cmd.status = vhp_pkg::ST_HRD;
          end else begin
            cpb_last_next = v[4:0];
            cpb_pos_next = 5'd0;
          end
        end
        vhp_pkg::E_CBR: begin
          if (cpb_pos >= cpb_last) phase_next = vhp_pkg::E_INIT_LEN;
          else begin
            cpb_pos_next = cpb_pos + 5'd1;
            phase_next = vhp_pkg::E_BR_VAL;
          end
        end
        vhp_pkg::E_TOFF_LEN:
          phase_next = hrd_which ? vhp_pkg::E_LOW_DELAY : vhp_pkg::E_VCL_FLAG;
        vhp_pkg::E_VCL_FLAG: begin
          if (v[0]) begin
            hrd_which_next = 1'b1;
            phase_next = vhp_pkg::E_CPB_CNT;
          end else if (nal_present_next) begin
            cmd.burst = vhp_pkg::B_HRD_VCL;
            phase_next = vhp_pkg::E_LOW_DELAY;
          end else begin
            cmd.burst = vhp_pkg::B_HRD_VCLLD;
            cmd.aux = {4'd0, ~fixed_rate_next};
            phase_next = vhp_pkg::E_PIC_STRUCT;
          end
        end
        vhp_pkg::E_BSR_FLAG: begin
          if (!v[0]) begin
            intra = constraint_three &&
                    (profile == 8'd44 || profile == 8'd86 || profile == 8'd100 ||
                     profile == 8'd110 || profile == 8'd122 || profile == 8'd244);
            cmd.burst = vhp_pkg::B_RESTRICT;
            cmd.aux = intra ? 5'd0 : max_dpb;
            stop = 1'b1;
          end
        end
        vhp_pkg::E_BYTES_DEN, vhp_pkg::E_BITS_DEN: begin
          if (v > 32'd16) begin
            stop = 1'b1;
            cmd.status = vhp_pkg::ST_VUI;
          end
        end
        vhp_pkg::E_MV_H, vhp_pkg::E_MV_V: begin
          if (v > 32'd15) begin
            stop = 1'b1;
            cmd.status = vhp_pkg::ST_VUI;
          end
        end
        vhp_pkg::E_REORDER: begin
          if (v > {27'd0, max_dpb}) begin
            stop = 1'b1;
            cmd.status = vhp_pkg::ST_VUI;
          end
        end
        vhp_pkg::E_DECBUF: begin
          stop = 1'b1;
          cmd.status = (v > {27'd0, max_dpb}) ? vhp_pkg::ST_VUI : vhp_pkg::ST_OK;
        end
        default: phase_next = c_phase + 6'd1;
      endcase
      if (stop) begin
        cmd.done = 1'b1;
        phase_next = vhp_pkg::PHASE_IDLE;
      end else if (do_enter) begin
        acc_next = 32'd0;
        zero_count_next = 6'd0;
        in_suffix_next = 1'b0;
        bits_left_next = vhp_pkg::elem_width(phase_next);
      end
    end
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      profile <= 8'd0;
      constraint_three <= 1'b0;
      max_dpb <= 5'd16;
      phase <= vhp_pkg::PHASE_IDLE;
      zero_count <= 6'd0;
      acc <= 32'd0;
      bits_left <= 6'd0;
      in_suffix <= 1'b0;
      hrd_which <= 1'b0;
      cpb_last <= 5'd0;
      cpb_pos <= 5'd0;
      nal_present <= 1'b0;
      fixed_rate <= 1'b0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          vhp_pkg::CFG_PROFILE:    profile <= cfg_data;
          vhp_pkg::CFG_CONSTRAINT: constraint_three <= cfg_data[0];
          vhp_pkg::CFG_MAX_DPB:    max_dpb <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase <= phase_next;
        zero_count <= zero_count_next;
        acc <= acc_next;
        bits_left <= bits_left_next;
        in_suffix <= in_suffix_next;
        hrd_which <= hrd_which_next;
        cpb_last <= cpb_last_next;
        cpb_pos <= cpb_pos_next;
        nal_present <= nal_present_next;
        fixed_rate <= fixed_rate_next;
      end
    end
  end

endmodule

@@ design/vhp_queue.sv @@
`include "vui_hrd_syntax_parser_defines.svh"

module vhp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vhp_pkg::cmd_t push_data,
  input  logic          pop,
  output vhp_pkg::cmd_t head,
  output logic          head_valid,
  output logic          full
);

  vhp_pkg::cmd_t mem [vhp_pkg::QDEPTH];
  logic [vhp_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [vhp_pkg::QPTR_W:0]   count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == (vhp_pkg::QPTR_W+1)'(vhp_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  `VHP_ASSERT_NEVER(a_q_overflow, clk, rst, push && full)
  `VHP_ASSERT_NEVER(a_q_underflow, clk, rst, pop && !head_valid)
  `VHP_ASSERT_NEXT(a_q_grow, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

@@ design/vhp_back.sv @@
`include "vui_hrd_syntax_parser_defines.svh"

module vhp_back (
  input  logic          clk,
  input  logic          rst,
  input  vhp_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [5:0]    element,
  output logic [4:0]    entry_index,
  output logic [31:0]   value,
  output logic          hrd_select,
  output logic [1:0]    status,
  output logic          done_res,
  output logic          last
);

  logic [2:0]     step;
  logic [2:0]     len;
  logic           is_last, load;
  vhp_pkg::item_t it;

  assign len     = vhp_pkg::burst_len(head.burst);
  assign is_last = (step == len);
  assign load    = !out_valid || !out_stall;
  assign pop     = load && head_valid && is_last;
  assign it      = vhp_pkg::burst_item(head.burst, step, head.aux);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step <= 3'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) step <= is_last ? 3'd0 : step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (step == 3'd0) begin
        element <= head.elem;
        entry_index <= head.idx;
        value <= head.value;
        hrd_select <= head.sel;
      end else begin
        element <= it.elem;
        entry_index <= 5'd0;
        value <= it.value;
        hrd_select <= it.sel;
      end
      status <= is_last ? head.status : vhp_pkg::ST_OK;
      done_res <= is_last && head.done;
      last <= is_last;
    end
  end

  `VHP_ASSERT_IMP(a_b_step_busy, clk, rst, step != 3'd0, head_valid)
  `VHP_ASSERT_IMP(a_b_step_range, clk, rst, head_valid, step <= len)
  `VHP_ASSERT_NEXT(a_b_pop_last, clk, rst, pop, out_valid && last)

endmodule
